// ===== design/gtfe_pkg.sv =====
// Shared types, constants and character helpers for the GPX trackpoint
// field extractor. No dependencies.
package gtfe_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [2:0] EXP_LAST = 3'd6;  // index of ';' in "&comma;"

  typedef enum logic [5:0] {
    PH_SEEK_LT = 6'd0, PH_TK_T, PH_TK_R, PH_TK_K, PH_TK_P, PH_TK_T2,
    PH_LAT_L, PH_LAT_A, PH_LAT_T, PH_LAT_EQ, PH_LAT_Q, PH_LAT_VAL,
    PH_LON_L, PH_LON_O, PH_LON_N, PH_LON_EQ, PH_LON_Q, PH_LON_VAL,
    PH_ELE_LT, PH_ELE_E, PH_ELE_L, PH_ELE_E2, PH_ELE_GT, PH_ELE_VAL,
    PH_ELE_SL, PH_ELE_CE, PH_ELE_CL, PH_ELE_CE2, PH_ELE_CGT,
    PH_TIME_LT, PH_TIME_T, PH_TIME_I, PH_TIME_M, PH_TIME_E, PH_TIME_GT,
    PH_TIME_VAL
  } phase_t;

  // One queued emit: a plain byte, or the "&comma;" expansion
  typedef struct packed {
    logic       expand;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] want_char(input phase_t ph);
    logic [7:0] r;
    case (ph)
      PH_SEEK_LT, PH_ELE_LT, PH_TIME_LT: r = CH_LT;
      PH_TK_T, PH_TK_T2, PH_LAT_T, PH_TIME_T: r = 8'h74;   // t
      PH_TK_R:   r = 8'h72;                                // r
      PH_TK_K:   r = 8'h6B;                                // k
      PH_TK_P:   r = 8'h70;                                // p
      PH_LAT_L, PH_LON_L, PH_ELE_L, PH_ELE_CL: r = 8'h6C;  // l
      PH_LAT_A:  r = 8'h61;                                // a
      PH_LAT_EQ, PH_LON_EQ: r = CH_EQ;
      PH_LON_O:  r = 8'h6F;                                // o
      PH_LON_N:  r = 8'h6E;                                // n
      PH_ELE_E, PH_ELE_E2, PH_ELE_CE, PH_ELE_CE2, PH_TIME_E: r = 8'h65;  // e
      PH_ELE_GT, PH_ELE_CGT, PH_TIME_GT: r = CH_GT;
      PH_ELE_SL: r = CH_SLASH;
      PH_TIME_I: r = 8'h69;                                // i
      PH_TIME_M: r = 8'h6D;                                // m
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  // Lowercase letters in the pattern also match their uppercase form
  function automatic logic char_match(input logic [7:0] c, input logic [7:0] e);
    logic r;
    if (e inside {[8'h61:8'h7A]}) r = (c == e) || (c == (e - 8'd32));
    else                          r = (c == e);
    return r;
  endfunction

  function automatic logic [7:0] comma_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h26;  // &
      3'd1:    r = 8'h63;  // c
      3'd2:    r = 8'h6F;  // o
      3'd3:    r = 8'h6D;  // m
      3'd4:    r = 8'h6D;  // m
      3'd5:    r = 8'h61;  // a
      default: r = 8'h3B;  // ;
    endcase
    return r;
  endfunction

endpackage

// ===== design/gtfe_front.sv =====
// Parser front end: takes one byte per transfer, tracks the search phase and
// quote skipping, and pushes emit ops to the queue. Uses gtfe_pkg.
module gtfe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  gtfe_pkg::q_stat_t q_stat,
  output logic             push,
  output gtfe_pkg::op_t    push_op
);
  import gtfe_pkg::*;

  phase_t phase, phase_next;
  logic   attr_skip, attr_skip_next;
  logic   attr_single, attr_single_next;
  logic   tag_skip, tag_skip_next;
  logic   tag_single, tag_single_next;

  logic   accept;
  logic   emit;
  logic   is_q, is_sq, hit, adv;
  phase_t ph_inc;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEEK_LT;
      attr_skip   <= 1'b0;
      attr_single <= 1'b0;
      tag_skip    <= 1'b0;
      tag_single  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      attr_skip   <= attr_skip_next;
      attr_single <= attr_single_next;
      tag_skip    <= tag_skip_next;
      tag_single  <= tag_single_next;
    end
  end

  always_comb begin
    is_q   = (in_byte == CH_DQ) || (in_byte == CH_SQ);
    is_sq  = (in_byte == CH_SQ);
    hit    = char_match(in_byte, want_char(phase));
    ph_inc = phase_t'(phase + 6'd1);
    adv    = 1'b0;

    phase_next       = phase;
    attr_skip_next   = attr_skip;
    attr_single_next = attr_single;
    tag_skip_next    = tag_skip;
    tag_single_next  = tag_single;
    emit             = 1'b0;
    push_op.expand   = 1'b0;
    push_op.data     = in_byte;

    case (phase)
      PH_LAT_L, PH_LON_L: begin
        if (!attr_skip && is_q) begin
          attr_skip_next   = 1'b1;
          attr_single_next = is_sq;
        end else if (attr_skip) begin
          if (is_q && (is_sq == attr_single)) attr_skip_next = 1'b0;
        end else if (hit) begin
          adv = 1'b1;
        end
      end
      PH_ELE_E, PH_ELE_L, PH_ELE_E2, PH_ELE_GT,
      PH_TIME_T, PH_TIME_I, PH_TIME_M, PH_TIME_E, PH_TIME_GT: begin
        if (!tag_skip && is_q) begin
          tag_skip_next   = 1'b1;
          tag_single_next = is_sq;
        end else if (tag_skip) begin
          if (is_q && (is_sq == tag_single)) tag_skip_next = 1'b0;
        end else if (hit) begin
          adv = 1'b1;
        end
      end
      PH_LAT_Q, PH_LON_Q: begin
        adv = is_q;
      end
      PH_LAT_VAL, PH_LON_VAL: begin
        emit = 1'b1;
        if (is_q) begin
          push_op.data = CH_COMMA;
          adv          = 1'b1;
        end
      end
      PH_ELE_VAL: begin
        emit = 1'b1;
        if (in_byte == CH_LT) begin
          push_op.data = CH_COMMA;
          adv          = 1'b1;
        end
      end
      PH_TIME_VAL: begin
        emit = 1'b1;
        if (in_byte == CH_COMMA) begin
          push_op.expand = 1'b1;
        end else if (in_byte == CH_LT) begin
          push_op.data = CH_NL;
          phase_next   = PH_SEEK_LT;
        end
      end
      default: begin
        // codes past the time value fall back to the start
        if (phase > PH_TIME_VAL) phase_next = PH_SEEK_LT;
        else                     adv = hit;
      end
    endcase

    if (adv) begin
      phase_next = ph_inc;
      if (ph_inc == PH_LAT_L || ph_inc == PH_LON_L)  attr_skip_next = 1'b0;
      if (ph_inc == PH_ELE_E || ph_inc == PH_TIME_T) tag_skip_next  = 1'b0;
    end
  end

endmodule

// ===== design/gtfe_queue.sv =====
// Short op queue between parser and emitter. Uses gtfe_pkg.
module gtfe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gtfe_pkg::op_t     push_op,
  input  logic              pop,
  output gtfe_pkg::op_t     head,
  output gtfe_pkg::q_stat_t q_stat
);
  import gtfe_pkg::*;

  op_t            entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign q_stat.full  = (count == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QAW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QAW'(1);
      if (do_push && !do_pop)      count <= count + (QAW+1)'(1);
      else if (do_pop && !do_push) count <= count - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

endmodule

// ===== design/gtfe_back.sv =====
// Emitter back end: drains queued ops into a registered output stage and
// expands the comma op into "&comma;". Uses gtfe_pkg.
module gtfe_back (
  input  logic              clk,
  input  logic              rst,
  input  gtfe_pkg::op_t     head,
  input  gtfe_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import gtfe_pkg::*;

  logic [2:0] cnt;
  logic       load;
  logic       fin;

  assign load = !q_stat.empty && (!out_valid || out_ready);
  assign fin  = !head.expand || (cnt == EXP_LAST);
  assign pop  = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) cnt <= fin ? 3'd0 : cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.expand ? comma_char(cnt) : head.data;
      out_last <= fin;
    end
  end

endmodule

// ===== design/gpx_trackpoint_field_extractor_core.sv =====
// Top level of the GPX trackpoint field extractor: parser, op queue and
// emitter. Uses gtfe_pkg, gtfe_front, gtfe_queue, gtfe_back.
//
// Takes one raw byte per transfer on the slave side and emits the lat, lon
// and ele text of each <trkpt>, each followed by a comma, then the time text
// and a newline, on the master side. Bytes are taken one per cycle. Each
// input byte yields zero or one output byte, except a comma inside the time
// text, which yields the seven bytes "&comma;" from the emitter; a four-entry
// op queue between parser and emitter absorbs these bursts, and the input
// stalls only while that queue is full. tlast is high on the final output
// byte caused by one input byte. Each op passes through the queue and then
// the registered output stage before output valid rises.
module gpx_trackpoint_field_extractor_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last_of_run
);
  import gtfe_pkg::*;

  op_t     push_op, head;
  q_stat_t q_stat;
  logic    push, pop;

  gtfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_op  (push_op)
  );

  gtfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  gtfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== design/gtfe_checker.sv =====
// Port-level checks for the GPX trackpoint field extractor, bound to the
// top level. Depends on gpx_trackpoint_field_extractor_core.
module gtfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // stalled input transfer is held by the source
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input changed while stalled");

  // output stage is empty right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // only the comma expansion produces non-final bytes
  a_nonlast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata == 8'h26 || m_tdata == 8'h63 ||
      m_tdata == 8'h6F || m_tdata == 8'h6D || m_tdata == 8'h61)
    else $error("unexpected non-final byte");

  // expansion runs without gaps once a byte of it is taken
  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside expansion");

endmodule

bind gpx_trackpoint_field_extractor_core gtfe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/tb.sv =====
// Testbench for gpx_trackpoint_field_extractor_core: drives byte streams of
// GPX trackpoints and checks the extracted text against a built-in parser.
// Depends on gtfe_pkg and the RTL of the extractor.
module tb;
  import gtfe_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] in_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic       m_tlast;   // last_of_run

  gpx_trackpoint_field_extractor_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Character awaited in each search phase; '.' marks phases with own handling
  string phase_text = "<trkptlat=..lon=..<ele>./ele><time>.";
  string comma_text = "&comma;";

  // Parser state
  phase_t phase;
  logic   attr_skip, attr_sq, tag_skip, tag_sq;

  out_char_t  pending[$];
  logic [7:0] rec[$];

  int  mismatches     = 0;
  int  chars_checked  = 0;
  int  bytes_sent     = 0;
  int  records_closed = 0;
  bit  src_idle       = 0;
  bit  snk_idle       = 0;
  int  stall_left     = 0;
  int  snk_roll;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic same_letter(input logic [7:0] c, input logic [7:0] e);
    if (e >= "a" && e <= "z") return (c == e) || (c == e - 8'd32);
    return c == e;
  endfunction

  function automatic logic [7:0] rcase(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  task automatic advance();
    phase = phase_t'(int'(phase) + 1);
    if (phase == PH_LAT_L || phase == PH_LON_L) attr_skip = 1'b0;
    if (phase == PH_ELE_E || phase == PH_TIME_T) tag_skip = 1'b0;
  endtask

  // Works out the text produced by one input byte and queues it
  task automatic parse_byte(input logic [7:0] c);
    logic       q, qs;
    logic [7:0] emit[$];
    q  = (c == CH_DQ) || (c == CH_SQ);
    qs = (c == CH_SQ);
    if (phase > PH_TIME_VAL) begin
      phase = PH_SEEK_LT;
    end else if (phase == PH_LAT_L || phase == PH_LON_L) begin
      if (!attr_skip && q) begin
        attr_skip = 1'b1;
        attr_sq   = qs;
      end else if (attr_skip) begin
        if (q && qs == attr_sq) attr_skip = 1'b0;
      end else if (same_letter(c, phase_text[int'(phase)])) begin
        advance();
      end
    end else if ((phase >= PH_ELE_E && phase <= PH_ELE_GT) ||
                 (phase >= PH_TIME_T && phase <= PH_TIME_GT)) begin
      if (!tag_skip && q) begin
        tag_skip = 1'b1;
        tag_sq   = qs;
      end else if (tag_skip) begin
        if (q && qs == tag_sq) tag_skip = 1'b0;
      end else if (same_letter(c, phase_text[int'(phase)])) begin
        advance();
      end
    end else if (phase == PH_LAT_Q || phase == PH_LON_Q) begin
      if (q) advance();
    end else if (phase == PH_LAT_VAL || phase == PH_LON_VAL) begin
      if (q) begin
        emit.push_back(CH_COMMA);
        advance();
      end else begin
        emit.push_back(c);
      end
    end else if (phase == PH_ELE_VAL) begin
      if (c == CH_LT) begin
        emit.push_back(CH_COMMA);
        advance();
      end else begin
        emit.push_back(c);
      end
    end else if (phase == PH_TIME_VAL) begin
      if (c == CH_COMMA) begin
        for (int i = 0; i < comma_text.len(); i++) emit.push_back(comma_text[i]);
      end else if (c == CH_LT) begin
        emit.push_back(CH_NL);
        phase = PH_SEEK_LT;
        records_closed++;
      end else begin
        emit.push_back(c);
      end
    end else if (same_letter(c, phase_text[int'(phase)])) begin
      advance();
    end
    foreach (emit[i]) pending.push_back('{ch: emit[i], last: (i == emit.size() - 1)});
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_rec();
    foreach (rec[i]) send_byte(rec[i]);
  endtask

  // Receiver: always ready while snk_idle is clear; otherwise ready most of the time, short stalls and the odd long one
  always @(negedge clk) begin
    if (!snk_idle) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      snk_roll = $urandom_range(0, 99);
      m_tready <= (snk_roll < 65);
      if (snk_roll >= 65 && snk_roll < 95) stall_left = $urandom_range(0, 2);
      else if (snk_roll >= 95) stall_left = $urandom_range(10, 30);
    end
  end

  always @(posedge clk) begin
    out_char_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: out_byte expected none actual %h last %b", $time, m_tdata, m_tlast);
      end else begin
        e = pending.pop_front();
        chars_checked++;
        if (m_tdata !== e.ch) begin
          mismatches++;
          $display("%0t: out_byte expected %h actual %h", $time, e.ch, m_tdata);
        end
        if (m_tlast !== e.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %b actual %b", $time, e.last, m_tlast);
        end
      end
    end
  end

  // Record building helpers
  task automatic add_word(input string s);
    for (int i = 0; i < s.len(); i++) rec.push_back(rcase(s[i]));
  endtask

  task automatic add_quoted();
    logic [7:0] qc, b;
    int         n;
    qc = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
    n  = $urandom_range(0, 4);
    rec.push_back(qc);
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == qc);
      rec.push_back(b);
    end
    if ($urandom_range(0, 2) == 0) add_word("lat=");
    rec.push_back(qc);
  endtask

  task automatic add_value(input int maxlen, input logic [7:0] stop_a,
                           input logic [7:0] stop_b, input int comma_pct);
    logic [7:0] b;
    int         n;
    n = $urandom_range(0, maxlen);
    repeat (n) begin
      if ($urandom_range(0, 99) < comma_pct) b = CH_COMMA;
      else do b = 8'($urandom_range(0, 255)); while (b == stop_a || b == stop_b);
      rec.push_back(b);
    end
  endtask

  // Tag name with quoted strings dropped in at random points
  task automatic add_tag(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 4) == 0) add_quoted();
      rec.push_back(rcase(s[i]));
    end
  endtask

  task automatic add_attr_value();
    rec.push_back($urandom_range(0, 1) ? CH_SQ : CH_DQ);
    add_value(4, CH_DQ, CH_SQ, 0);
    rec.push_back($urandom_range(0, 1) ? CH_SQ : CH_DQ);
  endtask

  task automatic build_record(input int comma_pct);
    int n;
    rec.delete();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 5)) rec.push_back(8'($urandom_range(0, 255)));
    add_word("<trkpt");
    if ($urandom_range(0, 1) == 1) begin
      add_word(" id=");
      add_quoted();
    end
    add_word(" lat=");
    add_attr_value();
    if ($urandom_range(0, 1) == 1) add_quoted();
    add_word(" lon=");
    add_attr_value();
    add_word(">\n<");
    add_tag("ele>");
    add_value(4, CH_LT, CH_LT, 0);
    add_word("</ele><");
    add_tag("time>");
    add_value(6, CH_LT, CH_LT, comma_pct);
    rec.push_back(CH_LT);
    // broken record now and then
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, rec.size() - 1);
      while (rec.size() > n) void'(rec.pop_back());
    end
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    while (pending.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Mixed case, quote skipping in attributes and tag names, value closed by
  // the other quote kind, extreme byte values, comma expansion
  task automatic test_directed();
    src_idle = 0;
    snk_idle = 0;
    send_text("<TrKpT x=\"lat='\" lAt='");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("\" LON=\"-1'>");
    send_text("<E'>'lE>7<x/ELE><TIME\">\">2,,");
    send_byte(8'h80);
    send_text("<");
  endtask

  task automatic test_records(input int budget, input int comma_pct);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_record(comma_pct);
      send_rec();
    end
  endtask

  task automatic test_back_to_back_records();
    src_idle = 0;
    snk_idle = 0;
    test_records(40, 10);
  endtask

  // Comma-heavy time text against a stalling receiver fills the op queue
  task automatic test_records_with_gaps();
    src_idle = 1;
    snk_idle = 1;
    test_records(70, 35);
  endtask

  task automatic test_raw_noise();
    src_idle = 1;
    snk_idle = 1;
    repeat (40) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    phase     = PH_SEEK_LT;
    attr_skip = 1'b0;
    attr_sq   = 1'b0;
    tag_skip  = 1'b0;
    tag_sq    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back_records();
    test_records_with_gaps();
    test_raw_noise();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drain();

    $display("tb: %0d input bytes, %0d output bytes checked, %0d records closed",
             bytes_sent, chars_checked, records_closed);
    if (pending.size() != 0)
      $display("%0t: %0d expected output bytes never arrived", $time, pending.size());
    if (mismatches == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== gpx_trackpoint_field_extractor_core.f =====
design/gtfe_pkg.sv
design/gtfe_front.sv
design/gtfe_queue.sv
design/gtfe_back.sv
design/gpx_trackpoint_field_extractor_core.sv
design/gtfe_checker.sv
bench/tb.sv
